// ----- rtl/core/hidp_pkg.sv -----
// Package for the handle-indexed dense pool: sizes, operation codes, status codes.
// Used by rtl/core/handle_indexed_dense_pool.sv. No dependencies.
`default_nettype none

package hidp_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int DATA_WIDTH = 32;

    // dense slot index and handle/count widths
    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int HANDLE_W = $clog2(NUM_SLOTS + 1);
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/hidp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hidp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/handle_indexed_dense_pool.sv -----
// Handle-indexed dense pool top level: control sequencer and four table RAMs.
// Depends on hidp_pkg and hidp_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: kind, handle,
//   payload. Output channel (out_valid / out_stall) returns one result item per
//   request: status, out_handle, out_payload, live_count.
//   One request is processed at a time. The table reads are issued in the
//   accept cycle. Add and rejected requests load the result in the execute
//   step. A get reads the item RAM there and returns the data from the get
//   step; a remove writes the tables there and unmaps its handle in the clear
//   step. The steps follow the dependent handle->slot->data reads and the two
//   writes a remove makes to the handle table. A new item is accepted as soon
//   as the sequencer is back in idle, so not while the last one is in progress.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, the sequencer holds at its final step until
//   the output register frees up, and in_stall stays high meanwhile.
//   Reset clears the per-entry valid bits of the handle table and free stack,
//   so there is no clearing pass: items are accepted the cycle after reset.
`default_nettype none

module handle_indexed_dense_pool (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [hidp_pkg::KIND_W-1:0]     kind,
    input  wire logic [hidp_pkg::HANDLE_W-1:0]   handle,
    input  wire logic [hidp_pkg::DATA_WIDTH-1:0] payload,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [hidp_pkg::STATUS_W-1:0]        status,
    output logic [hidp_pkg::HANDLE_W-1:0]        out_handle,
    output logic [hidp_pkg::DATA_WIDTH-1:0]      out_payload,
    output logic [hidp_pkg::HANDLE_W-1:0]        live_count
);

    import hidp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_GET  = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    localparam logic [HANDLE_W-1:0] FULL_COUNT = HANDLE_W'(NUM_SLOTS);
    localparam logic [HANDLE_W-1:0] ONE_H      = HANDLE_W'(1);

    logic [1:0]            state_reg, state_next;
    logic [HANDLE_W-1:0]   count_reg, count_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [DATA_WIDTH-1:0] payload_reg;

    logic [NUM_SLOTS-1:0]  h2s_vld_reg, fs_vld_reg;
    logic                  h2s_rvld_reg, fs_rvld_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [HANDLE_W-1:0]   out_handle_reg;
    logic [DATA_WIDTH-1:0] out_payload_reg;
    logic [HANDLE_W-1:0]   live_count_reg;

    // RAM ports
    logic                  item_we, item_re;
    logic [SLOT_W-1:0]     item_waddr, item_raddr;
    logic [DATA_WIDTH-1:0] item_wdata, item_rdata;
    logic                  s2h_we, s2h_re;
    logic [SLOT_W-1:0]     s2h_waddr, s2h_raddr;
    logic [HANDLE_W-1:0]   s2h_wdata, s2h_rdata;
    logic                  h2s_we, h2s_re;
    logic [SLOT_W-1:0]     h2s_waddr, h2s_raddr;
    logic [HANDLE_W-1:0]   h2s_wdata, h2s_rdata;
    logic                  fs_we, fs_re;
    logic [SLOT_W-1:0]     fs_waddr, fs_raddr;
    logic [HANDLE_W-1:0]   fs_wdata, fs_rdata;

    logic                  accept;
    logic                  out_free;
    logic                  res_load;
    logic [STATUS_W-1:0]   res_status;
    logic [HANDLE_W-1:0]   res_handle;
    logic [DATA_WIDTH-1:0] res_payload;

    logic                  h_in_range;
    logic [HANDLE_W-1:0]   map_val;
    logic                  hit;
    logic [SLOT_W-1:0]     hit_slot;
    logic [HANDLE_W-1:0]   new_handle;
    logic [HANDLE_W-1:0]   moved;
    logic [HANDLE_W-1:0]   last_idx;
    logic [HANDLE_W-1:0]   h_m1;
    logic [HANDLE_W-1:0]   moved_m1;
    logic [HANDLE_W-1:0]   nh_m1;
    logic [HANDLE_W-1:0]   pop_idx;
    logic [HANDLE_W-1:0]   push_idx;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign last_idx = count_reg - ONE_H;
    assign h_m1     = handle - ONE_H;
    assign pop_idx  = FULL_COUNT - ONE_H - count_reg;
    assign push_idx = FULL_COUNT - count_reg;

    // lookup of the latched handle
    assign h_in_range = (handle_reg != '0) && (handle_reg <= FULL_COUNT);
    assign map_val    = h2s_rvld_reg ? h2s_rdata : '0;
    assign hit        = h_in_range && (map_val != '0) && (map_val <= count_reg);
    assign hit_slot   = SLOT_W'(map_val - ONE_H);

    // unwritten free-stack entry at pop_idx holds NUM_SLOTS - pop_idx = count + 1
    assign new_handle = fs_rvld_reg ? fs_rdata : (count_reg + ONE_H);
    assign nh_m1      = new_handle - ONE_H;
    assign moved      = s2h_rdata;
    assign moved_m1   = moved - ONE_H;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        res_load    = 1'b0;
        res_status  = ST_OK;
        res_handle  = handle_reg;
        res_payload = '0;

        item_we    = 1'b0;
        item_waddr = count_reg[SLOT_W-1:0];
        item_wdata = payload_reg;
        item_re    = 1'b0;
        item_raddr = last_idx[SLOT_W-1:0];
        s2h_we     = 1'b0;
        s2h_waddr  = count_reg[SLOT_W-1:0];
        s2h_wdata  = new_handle;
        s2h_re     = 1'b0;
        s2h_raddr  = last_idx[SLOT_W-1:0];
        h2s_we     = 1'b0;
        h2s_waddr  = nh_m1[SLOT_W-1:0];
        h2s_wdata  = count_reg + ONE_H;
        h2s_re     = 1'b0;
        h2s_raddr  = h_m1[SLOT_W-1:0];
        fs_we      = 1'b0;
        fs_waddr   = push_idx[SLOT_W-1:0];
        fs_wdata   = handle_reg;
        fs_re      = 1'b0;
        fs_raddr   = pop_idx[SLOT_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_re    = 1'b1;
                    s2h_re     = 1'b1;
                    h2s_re     = 1'b1;
                    fs_re      = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (out_free)
                        begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status = ST_FULL;
                                res_handle = '0;
                            end
                            else
                            begin
                                item_we    = 1'b1;
                                s2h_we     = 1'b1;
                                h2s_we     = 1'b1;
                                count_next = count_reg + ONE_H;
                                res_handle = new_handle;
                            end
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!hit)
                        begin
                            if (out_free)
                            begin
                                res_load   = 1'b1;
                                res_status = ST_INVALID;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            // last item moves into the freed slot
                            item_we    = 1'b1;
                            item_waddr = hit_slot;
                            item_wdata = item_rdata;
                            s2h_we     = 1'b1;
                            s2h_waddr  = hit_slot;
                            s2h_wdata  = moved;
                            h2s_we     = 1'b1;
                            h2s_waddr  = moved_m1[SLOT_W-1:0];
                            h2s_wdata  = map_val;
                            fs_we      = 1'b1;
                            count_next = count_reg - ONE_H;
                            state_next = S_CLR;
                        end
                    end
                    KIND_GET:
                    begin
                        if (!hit)
                        begin
                            if (out_free)
                            begin
                                res_load   = 1'b1;
                                res_status = ST_INVALID;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            item_re    = 1'b1;
                            item_raddr = hit_slot;
                            state_next = S_GET;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            res_load   = 1'b1;
                            res_status = ST_INVALID;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_GET:
            begin
                if (out_free)
                begin
                    res_load    = 1'b1;
                    res_payload = item_rdata;
                    state_next  = S_IDLE;
                end
            end
            S_CLR:
            begin
                // after the moved handle's update, so a self-move ends unmapped
                h2s_we    = 1'b1;
                h2s_waddr = SLOT_W'(handle_reg - ONE_H);
                h2s_wdata = '0;
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            h2s_vld_reg   <= '0;
            fs_vld_reg    <= '0;
            h2s_rvld_reg  <= 1'b0;
            fs_rvld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (h2s_we)
            begin
                h2s_vld_reg[h2s_waddr] <= 1'b1;
            end
            if (fs_we)
            begin
                fs_vld_reg[fs_waddr] <= 1'b1;
            end
            if (h2s_re)
            begin
                h2s_rvld_reg <= h2s_vld_reg[h2s_raddr];
            end
            if (fs_re)
            begin
                fs_rvld_reg <= fs_vld_reg[fs_raddr];
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            handle_reg  <= handle;
            payload_reg <= payload;
        end
        if (res_load)
        begin
            status_reg      <= res_status;
            out_handle_reg  <= res_handle;
            out_payload_reg <= res_payload;
            live_count_reg  <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_handle  = out_handle_reg;
    assign out_payload = out_payload_reg;
    assign live_count  = live_count_reg;

    hidp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_SLOTS)) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (item_wdata),
        .re    (item_re),
        .raddr (item_raddr),
        .rdata (item_rdata)
    );

    hidp_ram #(.WIDTH(HANDLE_W), .DEPTH(NUM_SLOTS)) u_s2h_ram (
        .clk   (clk),
        .we    (s2h_we),
        .waddr (s2h_waddr),
        .wdata (s2h_wdata),
        .re    (s2h_re),
        .raddr (s2h_raddr),
        .rdata (s2h_rdata)
    );

    hidp_ram #(.WIDTH(HANDLE_W), .DEPTH(NUM_SLOTS)) u_h2s_ram (
        .clk   (clk),
        .we    (h2s_we),
        .waddr (h2s_waddr),
        .wdata (h2s_wdata),
        .re    (h2s_re),
        .raddr (h2s_raddr),
        .rdata (h2s_rdata)
    );

    hidp_ram #(.WIDTH(HANDLE_W), .DEPTH(NUM_SLOTS)) u_fs_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for handle_indexed_dense_pool: directed and random add/remove/get and reserved-kind traffic,
// checked item by item against a behavioral model of the pool kept in this file.
// Depends on hidp_pkg and the RTL of handle_indexed_dense_pool.
`timescale 1ns / 100ps

module tb_top;

    import hidp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [KIND_W-1:0]     op;
        logic [HANDLE_W-1:0]   hdl;
        logic [DATA_WIDTH-1:0] data;
    } pool_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [HANDLE_W-1:0]   hdl;
        logic [DATA_WIDTH-1:0] data;
        logic [HANDLE_W-1:0]   count;
    } pool_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = '0;
    logic [HANDLE_W-1:0]   handle = '0;
    logic [DATA_WIDTH-1:0] payload = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   out_handle;
    logic [DATA_WIDTH-1:0] out_payload;
    logic [HANDLE_W-1:0]   live_count;

    // pool model: slot_of_handle holds slot+1, 0 when unmapped
    logic [HANDLE_W-1:0]   slot_of_handle [NUM_SLOTS];
    logic [HANDLE_W-1:0]   handle_of_slot [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] data_at_slot [NUM_SLOTS];
    logic [HANDLE_W-1:0]   spare_handles [NUM_SLOTS];
    logic [HANDLE_W-1:0]   free_depth;
    logic [HANDLE_W-1:0]   live_items;

    pool_req_t    pending_requests[$];
    pool_result_t expected_results[$];
    pool_result_t oldest_result;
    bit           item_taken = 1'b0;
    int           send_gap_pct = 31;
    int           recv_stall_pct = 60;
    int           mismatch_count = 0;

    handle_indexed_dense_pool dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .handle      (handle),
        .payload     (payload),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_handle  (out_handle),
        .out_payload (out_payload),
        .live_count  (live_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the pool model and returns the result it gives.
    function automatic pool_result_t apply_pool_request(pool_req_t rq);
        pool_result_t        r;
        logic [HANDLE_W-1:0] mapped;
        logic [HANDLE_W-1:0] moved;
        logic [HANDLE_W-1:0] fresh;
        int                  slot;
        int                  last;
        bit                  found;

        r.status = ST_OK;
        r.hdl    = rq.hdl;
        r.data   = '0;
        found    = 1'b0;
        slot     = 0;
        if (rq.hdl >= 1 && rq.hdl <= NUM_SLOTS)
        begin
            mapped = slot_of_handle[rq.hdl - 1];
            if (mapped != 0 && mapped <= live_items)
            begin
                found = 1'b1;
                slot  = int'(mapped) - 1;
            end
        end

        case (rq.op)
            KIND_ADD:
            begin
                if (free_depth == 0 || live_items >= NUM_SLOTS)
                begin
                    r.status = ST_FULL;
                    r.hdl    = '0;
                end
                else
                begin
                    free_depth = free_depth - 1'b1;
                    fresh = spare_handles[free_depth];
                    slot  = int'(live_items);
                    data_at_slot[slot]       = rq.data;
                    handle_of_slot[slot]     = fresh;
                    slot_of_handle[fresh - 1] = HANDLE_W'(slot + 1);
                    live_items = live_items + 1'b1;
                    r.hdl = fresh;
                end
            end
            KIND_REMOVE:
            begin
                if (!found)
                    r.status = ST_INVALID;
                else
                begin
                    if (free_depth < NUM_SLOTS)
                    begin
                        spare_handles[free_depth] = rq.hdl;
                        free_depth = free_depth + 1'b1;
                    end
                    // swap-remove: last item fills the hole (may be itself)
                    last  = int'(live_items) - 1;
                    moved = handle_of_slot[last];
                    data_at_slot[slot]   = data_at_slot[last];
                    handle_of_slot[slot] = moved;
                    handle_of_slot[last] = '0;
                    slot_of_handle[moved - 1]  = HANDLE_W'(slot + 1);
                    slot_of_handle[rq.hdl - 1] = '0;
                    live_items = live_items - 1'b1;
                end
            end
            KIND_GET:
            begin
                if (!found)
                    r.status = ST_INVALID;
                else
                    r.data = data_at_slot[slot];
            end
            default:
                r.status = ST_INVALID;
        endcase
        r.count = live_items;
        return r;
    endfunction

    function automatic void queue_request(logic [KIND_W-1:0] op, int hdl,
                                          logic [DATA_WIDTH-1:0] data);
        pool_req_t rq;

        rq.op   = op;
        rq.hdl  = HANDLE_W'(hdl);
        rq.data = data;
        pending_requests.push_back(rq);
    endfunction

    // Driver: inputs change on the falling edge; a presented item is held until taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || item_taken)
            begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    kind     <= pending_requests[0].op;
                    handle   <= pending_requests[0].hdl;
                    payload  <= pending_requests[0].data;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
        item_taken = 1'b0;
    end

    // Monitor: requests and results are sampled on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_pool_request(pending_requests[0]));
                void'(pending_requests.pop_front());
                item_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d handle %0d",
                           status, out_handle);
                    mismatch_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (status !== oldest_result.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest_result.status, status);
                        mismatch_count++;
                    end
                    if (out_handle !== oldest_result.hdl)
                    begin
                        $error("out_handle: expected %0d, got %0d",
                               oldest_result.hdl, out_handle);
                        mismatch_count++;
                    end
                    if (out_payload !== oldest_result.data)
                    begin
                        $error("out_payload: expected %h, got %h",
                               oldest_result.data, out_payload);
                        mismatch_count++;
                    end
                    if (live_count !== oldest_result.count)
                    begin
                        $error("live_count: expected %0d, got %0d",
                               oldest_result.count, live_count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        pool_req_t rq;
        int        k;
        int        roll;
        int        add_pct;
        bit        draining;

        draining = 1'b0;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            slot_of_handle[k] = '0;
            handle_of_slot[k] = '0;
            data_at_slot[k]   = '0;
            spare_handles[k]  = HANDLE_W'(NUM_SLOTS - k);
        end
        free_depth = HANDLE_W'(NUM_SLOTS);
        live_items = '0;

        // lookups on an empty pool, reserved kind, then a small add/remove walk
        queue_request(KIND_GET, 0, 32'h0000_0000);
        queue_request(KIND_REMOVE, 1, 32'h1111_1111);
        queue_request(KIND_UNUSED, 127, 32'hFFFF_FFFF);
        queue_request(KIND_ADD, 0, 32'h0000_0000);
        queue_request(KIND_ADD, 0, 32'hFFFF_FFFF);
        queue_request(KIND_ADD, 0, 32'h5A5A_5A5A);
        queue_request(KIND_GET, 1, 32'h0000_0000);
        queue_request(KIND_GET, 2, 32'h0000_0000);
        queue_request(KIND_GET, 64, 32'h0000_0000);
        queue_request(KIND_REMOVE, 0, 32'h0000_0000);
        queue_request(KIND_REMOVE, 1, 32'h0000_0000);
        queue_request(KIND_GET, 3, 32'h0000_0000);
        queue_request(KIND_GET, 1, 32'h0000_0000);
        queue_request(KIND_REMOVE, 2, 32'h0000_0000);  // tail item removes onto itself
        queue_request(KIND_GET, 2, 32'h0000_0000);
        queue_request(KIND_ADD, 64, 32'hA5A5_A5A5);
        queue_request(KIND_REMOVE, 127, 32'h0000_0000);
        queue_request(KIND_GET, 100, 32'h0000_0000);
        queue_request(KIND_REMOVE, 3, 32'h0000_0000);
        queue_request(KIND_GET, 2, 32'hFFFF_FFFF);
        queue_request(KIND_REMOVE, 2, 32'h0000_0000);
        queue_request(KIND_REMOVE, 2, 32'h0000_0000);
        queue_request(KIND_ADD, 127, 32'h1234_5678);
        queue_request(KIND_GET, 1, 32'h0000_0000);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 0 || k == RANDOM_ITEMS / 3 || k == 2 * RANDOM_ITEMS / 3)
            begin
                // hold off until the pool has answered everything sent so far
                while (pending_requests.size() != 0 || expected_results.size() != 0)
                begin
                    @(posedge clk);
                    #1;
                end
                if (k == RANDOM_ITEMS / 3)
                begin
                    send_gap_pct   = 60;
                    recv_stall_pct = 31;
                end
                else if (k != 0)
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            end
            // next item is chosen from the model state after the previous one
            while (pending_requests.size() != 0)
            begin
                @(posedge clk);
                #1;
            end

            if (live_items == NUM_SLOTS && $urandom_range(0, 7) == 0)
                draining = 1'b1;
            if (live_items == 0)
                draining = 1'b0;
            add_pct = draining ? 25 : 60;

            roll    = $urandom_range(0, 99);
            rq.data = $urandom();
            rq.hdl  = HANDLE_W'($urandom_range(0, 127));
            if (roll < add_pct)
                rq.op = KIND_ADD;
            else if (roll < 92)
            begin
                rq.op = ($urandom_range(0, 99) < (draining ? 65 : 45)) ? KIND_REMOVE
                                                                       : KIND_GET;
                if (live_items > 0)
                    rq.hdl = handle_of_slot[$urandom_range(0, live_items - 1)];
            end
            else
                rq.op = KIND_W'($urandom_range(0, 3));
            pending_requests.push_back(rq);
        end

        while (pending_requests.size() != 0 || expected_results.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
